>>> hdl/timer_queue_scheduler_core_macros.svh
// assertion macros shared by the timer queue scheduler modules
`ifndef TIMER_QUEUE_SCHEDULER_CORE_MACROS_SVH
`define TIMER_QUEUE_SCHEDULER_CORE_MACROS_SVH

// condition that must hold on every clock edge out of reset
`define TQS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: lbl");

// antecedent implies consequent on the next clock edge
`define TQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

// antecedent implies consequent on the same clock edge
`define TQS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

`endif

>>> hdl/tqs_pkg.sv
// shared types and constants of the timer queue scheduler
package tqs_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int ACTION_BITS = 16;
	localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	localparam logic [23:0] REM_MAX = 24'hFF_FFFF;
	localparam logic [31:0] KEY_BIAS = 32'h8000_0000;

	typedef logic [SLOT_W-1:0]      slot_idx_t;
	typedef logic [ACTION_BITS-1:0] act_t;

	typedef enum logic [1:0] {
		M_ADD    = 2'd0,
		M_CANCEL = 2'd1,
		M_TICK   = 2'd2,
		M_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		K_ADDED     = 3'd0,
		K_FULL      = 3'd1,
		K_CANCEL    = 3'd2,
		K_EXPIRED   = 3'd3,
		K_NEXT      = 3'd4,
		K_TICK_DONE = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DECIDE
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] now_ms;
		logic [23:0] delay_ms;
		logic [15:0] callback_id;
		logic [3:0]  handle;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [15:0] action_id;
		logic [23:0] remaining_ms;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic  cap_in;
		logic  scan_start;
		logic  free_best;
		logic  do_add;
		logic  do_cancel;
		logic  emit;
		kind_t emit_kind;
		logic  emit_last;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  out_free;
		logic  table_full;
		logic  scan_done;
		logic  best_vld;
		logic  best_armed;
		logic  best_due;
	} dp_status_t;

	function automatic logic [3:0] slot_to_out(slot_idx_t idx);
		logic [31:0] w;
		w = 32'(idx);
		return w[3:0];
	endfunction

	function automatic logic [15:0] act_to_out(act_t a);
		logic [31:0] w;
		w = 32'(a);
		return w[15:0];
	endfunction

endpackage

>>> hdl/tqs_datapath.sv
// timer table, head search scan and result register of the timer queue scheduler
`include "timer_queue_scheduler_core_macros.svh"

module tqs_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tqs_pkg::in_item_t    item,
	input  logic                 result_ready,
	output logic                 result_valid,
	output tqs_pkg::out_item_t   result,
	input  tqs_pkg::dp_cmd_t     cmd,
	output tqs_pkg::dp_status_t  status
);

	tqs_pkg::in_item_t in_q;

	logic [31:0]       due_mem [tqs_pkg::TIMER_SLOTS];
	tqs_pkg::act_t     act_mem [tqs_pkg::TIMER_SLOTS];
	logic [tqs_pkg::TIMER_SLOTS-1:0] occupied_q;
	logic [tqs_pkg::TIMER_SLOTS-1:0] armed_q;

	tqs_pkg::slot_idx_t scan_cnt_q;
	logic               scan_busy_q;

	logic [31:0]        rd_due_s1;
	tqs_pkg::act_t      rd_act_s1;
	tqs_pkg::slot_idx_t rd_idx_s1;
	logic               rd_vld_s1;
	logic               rd_last_s1;

	logic               best_vld_q;
	logic [31:0]        best_key_q;
	tqs_pkg::slot_idx_t best_idx_q;
	tqs_pkg::act_t      best_act_q;

	logic               out_valid_q;
	tqs_pkg::out_item_t out_q;

	tqs_pkg::slot_idx_t free_idx;
	logic               free_found;
	logic [31:0]        rd_key;
	logic [31:0]        best_diff;
	logic               best_due;
	logic [23:0]        rem;
	logic               scan_last;
	logic               handle_ok;
	tqs_pkg::slot_idx_t handle_idx;
	tqs_pkg::out_item_t out_next;

	// lowest free slot
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = tqs_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!occupied_q[i]) begin
				free_idx   = tqs_pkg::slot_idx_t'(i);
				free_found = 1'b1;
			end
		end
	end

	assign scan_last  = (scan_cnt_q == tqs_pkg::slot_idx_t'(tqs_pkg::TIMER_SLOTS - 1));
	assign rd_key     = (rd_due_s1 - in_q.now_ms) ^ tqs_pkg::KEY_BIAS;
	assign best_diff  = best_key_q ^ tqs_pkg::KEY_BIAS;
	assign best_due   = (best_diff == 32'd0) || best_diff[31];
	assign handle_ok  = (32'(in_q.handle) < 32'(tqs_pkg::TIMER_SLOTS));
	assign handle_idx = tqs_pkg::slot_idx_t'(in_q.handle);

	// time left saturates, overdue or empty queue reads zero
	always_comb begin
		if (!best_vld_q || best_due) begin
			rem = '0;
		end else if (best_diff > 32'(tqs_pkg::REM_MAX)) begin
			rem = tqs_pkg::REM_MAX;
		end else begin
			rem = best_diff[23:0];
		end
	end

	always_comb begin
		out_next      = '0;
		out_next.kind = cmd.emit_kind;
		out_next.last = cmd.emit_last;
		case (cmd.emit_kind)
			tqs_pkg::K_ADDED: begin
				out_next.slot = tqs_pkg::slot_to_out(free_idx);
			end
			tqs_pkg::K_EXPIRED: begin
				out_next.slot      = tqs_pkg::slot_to_out(best_idx_q);
				out_next.action_id = tqs_pkg::act_to_out(best_act_q);
			end
			tqs_pkg::K_NEXT: begin
				out_next.remaining_ms = rem;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			in_q <= item;
		end
	end

	// table writes and registered reads at the scan address
	always_ff @(posedge clk) begin
		if (cmd.do_add && free_found) begin
			due_mem[free_idx] <= in_q.now_ms + 32'(in_q.delay_ms);
			act_mem[free_idx] <= tqs_pkg::act_t'(in_q.callback_id);
		end
		rd_due_s1 <= due_mem[scan_cnt_q];
		rd_act_s1 <= act_mem[scan_cnt_q];
		rd_idx_s1 <= scan_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= '0;
			armed_q    <= '0;
		end else begin
			if (cmd.do_add && free_found) begin
				occupied_q[free_idx] <= 1'b1;
				armed_q[free_idx]    <= 1'b1;
			end
			if (cmd.do_cancel && handle_ok && occupied_q[handle_idx]) begin
				armed_q[handle_idx] <= 1'b0;
			end
			if (cmd.free_best) begin
				occupied_q[best_idx_q] <= 1'b0;
				armed_q[best_idx_q]    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q  <= '0;
			scan_busy_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			best_vld_q  <= 1'b0;
		end else begin
			rd_vld_s1  <= scan_busy_q;
			rd_last_s1 <= scan_busy_q && scan_last;
			if (cmd.scan_start) begin
				scan_cnt_q  <= '0;
				scan_busy_q <= 1'b1;
				best_vld_q  <= 1'b0;
			end else begin
				if (scan_busy_q) begin
					if (scan_last) begin
						scan_busy_q <= 1'b0;
					end else begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				// strict compare keeps the lower slot on ties
				if (rd_vld_s1 && occupied_q[rd_idx_s1] &&
						(!best_vld_q || rd_key < best_key_q)) begin
					best_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && occupied_q[rd_idx_s1] && (!best_vld_q || rd_key < best_key_q)) begin
			best_key_q <= rd_key;
			best_idx_q <= rd_idx_s1;
			best_act_q <= rd_act_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= out_next;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign status.mode       = tqs_pkg::mode_t'(in_q.mode);
	assign status.out_free   = !out_valid_q || result_ready;
	assign status.table_full = !free_found;
	assign status.scan_done  = rd_last_s1;
	assign status.best_vld   = best_vld_q;
	assign status.best_armed = armed_q[best_idx_q];
	assign status.best_due   = best_due;

	`TQS_ASSERT_ALWAYS(a_armed_occupied, clk, arst_n, (armed_q & ~occupied_q) == '0)
	`TQS_ASSERT_SAME(a_emit_room, clk, arst_n, cmd.emit, !out_valid_q || result_ready)
	`TQS_ASSERT_NEXT(a_scan_feeds_s1, clk, arst_n, scan_busy_q && !cmd.scan_start, rd_vld_s1)
	`TQS_ASSERT_SAME(a_free_valid_head, clk, arst_n, cmd.free_best, best_vld_q && !scan_busy_q)

endmodule

>>> hdl/tqs_ctrl.sv
// sequencing state machine of the timer queue scheduler
module tqs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  tqs_pkg::dp_status_t  status,
	output tqs_pkg::dp_cmd_t     cmd
);

	tqs_pkg::ctrl_state_t state_q;
	tqs_pkg::ctrl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tqs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next     = state_q;
		item_ready     = 1'b0;
		cmd            = '0;
		cmd.emit_kind  = tqs_pkg::K_ADDED;
		case (state_q)
			tqs_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.cap_in = 1'b1;
					state_next = tqs_pkg::ST_EXEC;
				end
			end
			tqs_pkg::ST_EXEC: begin
				case (status.mode)
					tqs_pkg::M_ADD: begin
						if (status.out_free) begin
							cmd.do_add    = 1'b1;
							cmd.emit      = 1'b1;
							cmd.emit_last = 1'b1;
							cmd.emit_kind = status.table_full ? tqs_pkg::K_FULL
								: tqs_pkg::K_ADDED;
							state_next    = tqs_pkg::ST_IDLE;
						end
					end
					tqs_pkg::M_CANCEL: begin
						if (status.out_free) begin
							cmd.do_cancel = 1'b1;
							cmd.emit      = 1'b1;
							cmd.emit_last = 1'b1;
							cmd.emit_kind = tqs_pkg::K_CANCEL;
							state_next    = tqs_pkg::ST_IDLE;
						end
					end
					default: begin
						cmd.scan_start = 1'b1;
						state_next     = tqs_pkg::ST_SCAN;
					end
				endcase
			end
			tqs_pkg::ST_SCAN: begin
				if (status.scan_done) begin
					state_next = tqs_pkg::ST_DECIDE;
				end
			end
			tqs_pkg::ST_DECIDE: begin
				if (status.best_vld && !status.best_armed) begin
					// cancelled head leaves the queue, search again
					cmd.free_best  = 1'b1;
					cmd.scan_start = 1'b1;
					state_next     = tqs_pkg::ST_SCAN;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.mode == tqs_pkg::M_TICK) begin
						if (status.best_vld && status.best_due) begin
							cmd.emit_kind  = tqs_pkg::K_EXPIRED;
							cmd.free_best  = 1'b1;
							cmd.scan_start = 1'b1;
							state_next     = tqs_pkg::ST_SCAN;
						end else begin
							cmd.emit_kind = tqs_pkg::K_TICK_DONE;
							cmd.emit_last = 1'b1;
							state_next    = tqs_pkg::ST_IDLE;
						end
					end else begin
						cmd.emit_kind = tqs_pkg::K_NEXT;
						cmd.emit_last = 1'b1;
						state_next    = tqs_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_next = tqs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/timer_queue_scheduler_core.sv
// Timer queue scheduler: a table of TIMER_SLOTS timers (16) with lazy cancel. An add or a
// cancel is registered at its transfer and loads its result into the output register from
// the execute state once the output is free. Tick and query find the queue head by scanning
// every slot of the due-time table, one slot per cycle through a registered read port, and
// each head search ends in the decision state; a tick searches again after each expired
// timer and each dropped cancelled head, a query after each dropped cancelled head.
// The next item is taken as soon as the last result is loaded, while
// that result still waits at the output; a stalled output holds the search at its head.
module timer_queue_scheduler_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  tqs_pkg::in_item_t   item,
	output logic                result_valid,
	input  logic                result_ready,
	output tqs_pkg::out_item_t  result
);

	tqs_pkg::dp_cmd_t    cmd;
	tqs_pkg::dp_status_t status;

	tqs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	tqs_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

>>> tb/tb_timer_queue_scheduler_core.sv
// testbench for timer_queue_scheduler_core: slot-table timer predictor, random traffic and stalls
`timescale 1ns / 100ps

module tb_timer_queue_scheduler_core;

	typedef struct {
		tqs_pkg::in_item_t it;
		bit                drain;
	} stim_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	tqs_pkg::in_item_t  item = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	tqs_pkg::out_item_t result;

	// predictor copy of the timer table
	bit [31:0] due_tbl [tqs_pkg::TIMER_SLOTS];
	bit [15:0] action_tbl [tqs_pkg::TIMER_SLOTS];
	bit        occ_tbl [tqs_pkg::TIMER_SLOTS];
	bit        armed_tbl [tqs_pkg::TIMER_SLOTS];

	stim_t              stim_q [$];
	tqs_pkg::out_item_t awaited_results [$];
	int        results_forecast = 0;
	int        results_seen = 0;
	int        mismatches = 0;

	int        gap_left = 0;
	int        burst_left = 1;
	int        stall_left = 0;
	logic [8:0] phase_cnt = '0;

	timer_queue_scheduler_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < 50)
			$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// lowest key (due - now, sign-biased) wins, ties to the lower slot
	function automatic int earliest_slot(logic [31:0] now);
		int best;
		int i;
		logic [31:0] key;
		logic [31:0] best_key;
		best = -1;
		best_key = '0;
		for (i = 0; i < tqs_pkg::TIMER_SLOTS; i++) begin
			if (occ_tbl[i]) begin
				key = (due_tbl[i] - now) ^ tqs_pkg::KEY_BIAS;
				if (best < 0 || key < best_key) begin
					best = i;
					best_key = key;
				end
			end
		end
		return best;
	endfunction

	function automatic void push_result(tqs_pkg::out_item_t r);
		awaited_results.push_back(r);
		results_forecast++;
	endfunction

	function automatic void predict_timer_op(tqs_pkg::in_item_t it);
		tqs_pkg::out_item_t r;
		int hd;
		int i;
		bit busy;
		bit found;
		logic [31:0] d;
		r = '0;
		r.last = 1'b1;
		case (tqs_pkg::mode_t'(it.mode))
			tqs_pkg::M_ADD: begin
				found = 1'b0;
				for (i = 0; i < tqs_pkg::TIMER_SLOTS && !found; i++) begin
					if (!occ_tbl[i]) begin
						due_tbl[i] = it.now_ms + 32'(it.delay_ms);
						action_tbl[i] = it.callback_id;
						occ_tbl[i] = 1'b1;
						armed_tbl[i] = 1'b1;
						r.kind = tqs_pkg::K_ADDED;
						r.slot = 4'(i);
						found = 1'b1;
					end
				end
				if (!found)
					r.kind = tqs_pkg::K_FULL;
				push_result(r);
			end
			tqs_pkg::M_CANCEL: begin
				if (occ_tbl[it.handle])
					armed_tbl[it.handle] = 1'b0;
				r.kind = tqs_pkg::K_CANCEL;
				push_result(r);
			end
			tqs_pkg::M_TICK: begin
				busy = 1'b1;
				while (busy) begin
					hd = earliest_slot(it.now_ms);
					if (hd < 0) begin
						busy = 1'b0;
					end else if (!armed_tbl[hd]) begin
						occ_tbl[hd] = 1'b0;
					end else begin
						d = due_tbl[hd] - it.now_ms;
						if (d != 0 && !d[31]) begin
							busy = 1'b0;
						end else begin
							r.kind = tqs_pkg::K_EXPIRED;
							r.slot = 4'(hd);
							r.action_id = action_tbl[hd];
							r.last = 1'b0;
							push_result(r);
							occ_tbl[hd] = 1'b0;
							armed_tbl[hd] = 1'b0;
						end
					end
				end
				r = '0;
				r.kind = tqs_pkg::K_TICK_DONE;
				r.last = 1'b1;
				push_result(r);
			end
			default: begin
				r.kind = tqs_pkg::K_NEXT;
				busy = 1'b1;
				while (busy) begin
					hd = earliest_slot(it.now_ms);
					if (hd < 0) begin
						busy = 1'b0;
					end else if (!armed_tbl[hd]) begin
						occ_tbl[hd] = 1'b0;
					end else begin
						d = due_tbl[hd] - it.now_ms;
						// overdue or due now reports 0, far away saturates
						if (d != 0 && !d[31])
							r.remaining_ms = (d > 32'(tqs_pkg::REM_MAX)) ?
								tqs_pkg::REM_MAX : d[23:0];
						busy = 1'b0;
					end
				end
				push_result(r);
			end
		endcase
	endfunction

	task automatic queue_item(tqs_pkg::mode_t m, logic [31:0] now, logic [23:0] dly,
			logic [15:0] cb, logic [3:0] h, bit drain);
		stim_t s;
		s.it.mode = m;
		s.it.now_ms = now;
		s.it.delay_ms = dly;
		s.it.callback_id = cb;
		s.it.handle = h;
		s.drain = drain;
		stim_q.push_back(s);
	endtask

	// driver: bursts with random gaps, optional hold until all results are back
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			gap_left <= 0;
			burst_left <= 1;
		end else begin
			if (item_valid && item_ready)
				predict_timer_op(item);
			if (!item_valid || item_ready) begin
				if (gap_left != 0) begin
					item_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (stim_q.size() == 0 ||
						(stim_q[0].drain && results_forecast != results_seen)) begin
					item_valid <= 1'b0;
				end else begin
					item <= stim_q[0].it;
					item_valid <= 1'b1;
					stim_q.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// monitor: checks each result transfer, stalls in short bursts with calm stretches
	always @(posedge clk or negedge arst_n) begin : monitor
		tqs_pkg::out_item_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left <= 0;
			phase_cnt <= '0;
			results_seen <= 0;
		end else begin
			if (result_valid && result_ready) begin
				results_seen <= results_seen + 1;
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing awaited, kind", 32'(result.kind), 0);
				end else begin
					want = awaited_results.pop_front();
					if (result.kind !== want.kind)
						report_mismatch("kind", 32'(result.kind), 32'(want.kind));
					if (result.slot !== want.slot)
						report_mismatch("slot", 32'(result.slot), 32'(want.slot));
					if (result.action_id !== want.action_id)
						report_mismatch("action_id", 32'(result.action_id),
							32'(want.action_id));
					if (result.remaining_ms !== want.remaining_ms)
						report_mismatch("remaining_ms", 32'(result.remaining_ms),
							32'(want.remaining_ms));
					if (result.last !== want.last)
						report_mismatch("last", 32'(result.last), 32'(want.last));
				end
			end
			phase_cnt <= phase_cnt + 1'b1;
			if (stall_left != 0) begin
				result_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (phase_cnt[8:7] != 2'b11 && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				stall_left <= $urandom_range(0, 7);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		int n_rand;
		int sel;
		int len;
		int k;
		logic [31:0] t_now;
		logic [23:0] dly;

		// directed: empty table, extremes of delay, wrap, ties, lazy cancel behind the head
		queue_item(tqs_pkg::M_TICK, 32'd0, 24'($urandom), 16'($urandom), 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_QUERY, 32'd0, 24'($urandom), 16'($urandom), 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_ADD, 32'd100, 24'd0, 16'hFFFF, 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_ADD, 32'd100, tqs_pkg::REM_MAX, 16'h0000, 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_QUERY, 32'd100, 24'($urandom), 16'($urandom), 4'($urandom),
			1'b0);
		queue_item(tqs_pkg::M_TICK, 32'd100, 24'($urandom), 16'($urandom), 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_QUERY, 32'd50, 24'($urandom), 16'($urandom), 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_ADD, 32'd200, 24'd10, 16'h1234, 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_CANCEL, 32'($urandom), 24'($urandom), 16'($urandom), 4'd0,
			1'b0);
		queue_item(tqs_pkg::M_CANCEL, 32'($urandom), 24'($urandom), 16'($urandom), 4'd15,
			1'b0);
		queue_item(tqs_pkg::M_QUERY, 32'd200, 24'($urandom), 16'($urandom), 4'($urandom),
			1'b0);
		queue_item(tqs_pkg::M_CANCEL, 32'($urandom), 24'($urandom), 16'($urandom), 4'd1,
			1'b0);
		queue_item(tqs_pkg::M_QUERY, 32'd200, 24'($urandom), 16'($urandom), 4'($urandom),
			1'b1);
		queue_item(tqs_pkg::M_ADD, 32'hFFFF_FFF0, 24'h20, 16'hAAAA, 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_ADD, 32'hFFFF_FFF0, 24'h5, 16'h5555, 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_TICK, 32'hFFFF_FFF8, 24'($urandom), 16'($urandom),
			4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_QUERY, 32'hFFFF_FFF8, 24'($urandom), 16'($urandom),
			4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_QUERY, 32'h20, 24'($urandom), 16'($urandom), 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_TICK, 32'h10, 24'($urandom), 16'($urandom), 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_ADD, 32'd1000, 24'd50, 16'd1, 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_ADD, 32'd1000, 24'd50, 16'd2, 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_ADD, 32'd1000, 24'd80, 16'd3, 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_ADD, 32'd1000, 24'd100, 16'd4, 4'($urandom), 1'b0);
		queue_item(tqs_pkg::M_CANCEL, 32'($urandom), 24'($urandom), 16'($urandom), 4'd3,
			1'b0);
		queue_item(tqs_pkg::M_TICK, 32'd1060, 24'($urandom), 16'($urandom), 4'($urandom),
			1'b0);
		queue_item(tqs_pkg::M_ADD, 32'd1060, 24'd7, 16'hBEEF, 4'($urandom), 1'b0);

		// random: mostly coherent timelines, some noise and time jumps
		n_rand = 0;
		t_now = 32'd2000;
		while (n_rand < 204) begin
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				len = ($urandom_range(0, 7) == 0) ? 17 : $urandom_range(1, 4);
				for (k = 0; k < len; k++) begin
					case ($urandom_range(0, 15))
						0: dly = 24'd0;
						1: dly = tqs_pkg::REM_MAX;
						2: dly = 24'($urandom);
						default: dly = 24'($urandom_range(1, 500));
					endcase
					queue_item(tqs_pkg::M_ADD, t_now, dly, 16'($urandom), 4'($urandom),
						$urandom_range(0, 39) == 0);
					t_now = t_now + $urandom_range(0, 3);
					n_rand++;
				end
			end else if (sel < 45) begin
				queue_item(tqs_pkg::M_CANCEL, 32'($urandom), 24'($urandom), 16'($urandom),
					4'($urandom), $urandom_range(0, 39) == 0);
				n_rand++;
			end else if (sel < 70) begin
				t_now = t_now + $urandom_range(0, 400);
				queue_item(tqs_pkg::M_TICK, t_now, 24'($urandom), 16'($urandom),
					4'($urandom), $urandom_range(0, 39) == 0);
				n_rand++;
			end else if (sel < 82) begin
				queue_item(tqs_pkg::M_QUERY, t_now, 24'($urandom), 16'($urandom),
					4'($urandom), $urandom_range(0, 39) == 0);
				n_rand++;
			end else if (sel < 92) begin
				queue_item(tqs_pkg::mode_t'($urandom_range(0, 3)), 32'($urandom),
					24'($urandom), 16'($urandom), 4'($urandom), 1'b0);
				n_rand++;
			end else begin
				t_now = ($urandom_range(0, 1) == 0) ? 32'($urandom) :
					32'hFFFF_FF00 + $urandom_range(0, 255);
			end
		end

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		while (stim_q.size() != 0 || item_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
		if (awaited_results.size() != 0)
			report_mismatch("results still awaited", 32'(awaited_results.size()), 0);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
